// ----- hw/rtl/bchs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bchs_pkg
// Shared widths, register indexes and defaults for the block to CHS address
// translator.
// ----------------------------------------------------------------------------
package bchs_pkg;

  localparam int ADDR_W     = 32;  // absolute sector and block index
  localparam int COUNT_W    = 8;   // block count and task file sector count
  localparam int HEADS_W    = 5;   // heads per cylinder register
  localparam int SPT_W      = 6;   // sectors per track register
  localparam int SPC_W      = HEADS_W + SPT_W;  // heads * sectors per track
  localparam int CYL_W      = 16;
  localparam int HEAD_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Quotient bits resolved per divider stage
  localparam int DIV_STEPS     = 4;
  localparam int SPLIT_STEPS_A = 6;
  localparam int SPLIT_STEPS_B = SPC_W - SPLIT_STEPS_A;

  localparam int SECTORS_PER_BLOCK_DEF = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADS_PER_CYLINDER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS_PER_TRACK  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_START    = 2'd2;

  // Reset values
  localparam logic [HEADS_W-1:0] HEADS_RST = 5'd16;
  localparam logic [SPT_W-1:0]   SPT_RST   = 6'd63;
  localparam logic [ADDR_W-1:0]  PSTART_RST = 32'd0;

endpackage
`default_nettype wire

// ----- hw/rtl/bchs_div_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bchs_div_stage
// One registered stage of a restoring divider: resolves STEPS quotient bits
// of a shifting numerator word and passes side data along with the item.
// ----------------------------------------------------------------------------
module bchs_div_stage #(
  parameter int W     = 32,
  parameter int RW    = 11,
  parameter int STEPS = 4,
  parameter int SW    = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [W-1:0]  in_num,
  input  wire logic [RW-1:0] in_rem,
  input  wire logic [SW-1:0] in_side,
  input  wire logic [RW-1:0] divisor,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [W-1:0]       out_num,
  output logic [RW-1:0]      out_rem,
  output logic [SW-1:0]      out_side
);

  logic [W-1:0]  num_v;
  logic [RW-1:0] rem_v;
  logic [RW:0]   trial;

  // Shift numerator bits into the partial remainder, quotient bits fill in
  // from the bottom of the same word.
  always_comb begin
    num_v = in_num;
    rem_v = in_rem;
    trial = '0;
    for (int s = 0; s < STEPS; s++) begin
      trial = {rem_v, num_v[W-1]};
      num_v = {num_v[W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial    = trial - {1'b0, divisor};
        num_v[0] = 1'b1;
      end
      rem_v = trial[RW-1:0];
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_num  <= num_v;
      out_rem  <= rem_v;
      out_side <= in_side;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/block_to_chs_address_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// block_to_chs_address_top
// Translates a partition-relative block request into a CHS task file address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries block_index and block_count.
//   Output channel (out_valid / out_stall) returns cylinder, head, sector,
//   sector_count and range_error, one result per request, in order.
//   Configuration channel (cfg_valid / cfg_ready) writes heads per cylinder,
//   sectors per track and the partition start; cfg_ready is always high.
//   Write configuration only while no request is in flight.
// Pipeline: one scaling stage, eight cylinder divider stages at four quotient
//   bits each, two head/sector divider stages and the output register.
// Throughput: one request per cycle. Each stage holds its item while the
//   next one is full, so a stall on the output fills bubbles first and then
//   backs up to in_stall without losing or repeating anything.
// Reset: rst clears all stage valid bits and loads the geometry 16 heads,
//   63 sectors per track, partition start 0.
// ----------------------------------------------------------------------------
module block_to_chs_address_top #(
  parameter int SECTORS_PER_BLOCK = bchs_pkg::SECTORS_PER_BLOCK_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [bchs_pkg::ADDR_W-1:0]      block_index,
  input  wire logic [bchs_pkg::COUNT_W-1:0]     block_count,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [bchs_pkg::CYL_W-1:0]            cylinder,
  output logic [bchs_pkg::HEAD_W-1:0]           head,
  output logic [bchs_pkg::SPT_W-1:0]            sector,
  output logic [bchs_pkg::COUNT_W-1:0]          sector_count,
  output logic                                  range_error,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bchs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bchs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int ADDR_W     = bchs_pkg::ADDR_W;
  localparam int COUNT_W    = bchs_pkg::COUNT_W;
  localparam int SPC_W      = bchs_pkg::SPC_W;
  localparam int SPT_W      = bchs_pkg::SPT_W;
  localparam int HEADS_W    = bchs_pkg::HEADS_W;
  localparam int CYL_W      = bchs_pkg::CYL_W;
  localparam int HEAD_W     = bchs_pkg::HEAD_W;
  localparam int NSECT_W    = $clog2(256 * SECTORS_PER_BLOCK);
  localparam int CYL_STAGES = ADDR_W / bchs_pkg::DIV_STEPS;
  localparam int SIDE1_W    = COUNT_W + 1;
  localparam int SIDE2_W    = CYL_W + COUNT_W + 1;
  localparam logic [ADDR_W-1:0]  SPB_ADDR  = ADDR_W'(SECTORS_PER_BLOCK);
  localparam logic [NSECT_W-1:0] SPB_NSECT = NSECT_W'(SECTORS_PER_BLOCK);
  localparam logic [NSECT_W-1:0] COUNT_MAX = NSECT_W'(255);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [HEADS_W-1:0] heads_per_cylinder;
  logic [SPT_W-1:0]   sectors_per_track;
  logic [ADDR_W-1:0]  partition_start;
  logic [HEADS_W-1:0] heads_eff;
  logic [SPT_W-1:0]   spt_eff;
  logic [SPC_W-1:0]   spc;
  logic [SPC_W-1:0]   spt_div;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heads_per_cylinder <= bchs_pkg::HEADS_RST;
      sectors_per_track  <= bchs_pkg::SPT_RST;
      partition_start    <= bchs_pkg::PSTART_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bchs_pkg::REG_HEADS_PER_CYLINDER: heads_per_cylinder <= cfg_data[HEADS_W-1:0];
        bchs_pkg::REG_SECTORS_PER_TRACK:  sectors_per_track  <= cfg_data[SPT_W-1:0];
        bchs_pkg::REG_PARTITION_START:    partition_start    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero geometry counts as one
  assign heads_eff = (heads_per_cylinder == '0) ? HEADS_W'(1) : heads_per_cylinder;
  assign spt_eff   = (sectors_per_track == '0) ? SPT_W'(1) : sectors_per_track;

  always_ff @(posedge clk) begin
    spc     <= SPC_W'(heads_eff) * SPC_W'(spt_eff);
    spt_div <= SPC_W'(spt_eff);
  end

  // --------------------------------------------------------------------------
  // Front stage: scale index and count, add partition start
  // --------------------------------------------------------------------------
  logic                f_valid;
  logic                f_ready;
  logic [ADDR_W-1:0]   f_abs;
  logic [COUNT_W-1:0]  f_nsect;
  logic                f_cnt_err;
  logic [NSECT_W-1:0]  nsect_full;

  assign nsect_full = NSECT_W'(block_count) * SPB_NSECT;

  logic c_ready [CYL_STAGES+1];
  logic c_valid [CYL_STAGES+1];
  logic [ADDR_W-1:0]  c_num  [CYL_STAGES+1];
  logic [SPC_W-1:0]   c_rem  [CYL_STAGES+1];
  logic [SIDE1_W-1:0] c_side [CYL_STAGES+1];

  assign f_ready  = !f_valid || c_ready[0];
  assign in_stall = !f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (f_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && f_ready) begin
      f_abs     <= block_index * SPB_ADDR + partition_start;
      f_nsect   <= nsect_full[COUNT_W-1:0];
      f_cnt_err <= (nsect_full > COUNT_MAX);
    end
  end

  // --------------------------------------------------------------------------
  // Cylinder divider: absolute sector / (heads * sectors per track)
  // --------------------------------------------------------------------------
  assign c_valid[0] = f_valid;
  assign c_num[0]   = f_abs;
  assign c_rem[0]   = '0;
  assign c_side[0]  = {f_cnt_err, f_nsect};

  for (genvar g = 0; g < CYL_STAGES; g++) begin : g_cyl
    bchs_div_stage #(
      .W     (ADDR_W),
      .RW    (SPC_W),
      .STEPS (bchs_pkg::DIV_STEPS),
      .SW    (SIDE1_W)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (c_valid[g]),
      .in_ready  (c_ready[g]),
      .in_num    (c_num[g]),
      .in_rem    (c_rem[g]),
      .in_side   (c_side[g]),
      .divisor   (spc),
      .out_valid (c_valid[g+1]),
      .out_ready (c_ready[g+1]),
      .out_num   (c_num[g+1]),
      .out_rem   (c_rem[g+1]),
      .out_side  (c_side[g+1])
    );
  end

  // --------------------------------------------------------------------------
  // Head/sector divider: remainder / sectors per track, two stages
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]  cyl_q;
  logic               cyl_err;
  logic [SIDE2_W-1:0] s0_side;
  logic               s1_valid;
  logic               s1_ready;
  logic [SPC_W-1:0]   s1_num;
  logic [SPC_W-1:0]   s1_rem;
  logic [SIDE2_W-1:0] s1_side;
  logic               s2_valid;
  logic               s2_ready;
  logic [SPC_W-1:0]   s2_num;
  logic [SPC_W-1:0]   s2_rem;
  logic [SIDE2_W-1:0] s2_side;

  assign cyl_q   = c_num[CYL_STAGES];
  assign cyl_err = (cyl_q[ADDR_W-1:CYL_W] != '0) || c_side[CYL_STAGES][COUNT_W];
  assign s0_side = {cyl_err, c_side[CYL_STAGES][COUNT_W-1:0], cyl_q[CYL_W-1:0]};

  bchs_div_stage #(
    .W     (SPC_W),
    .RW    (SPC_W),
    .STEPS (bchs_pkg::SPLIT_STEPS_A),
    .SW    (SIDE2_W)
  ) u_split_a (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid[CYL_STAGES]),
    .in_ready  (c_ready[CYL_STAGES]),
    .in_num    (c_rem[CYL_STAGES]),
    .in_rem    ('0),
    .in_side   (s0_side),
    .divisor   (spt_div),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_num   (s1_num),
    .out_rem   (s1_rem),
    .out_side  (s1_side)
  );

  bchs_div_stage #(
    .W     (SPC_W),
    .RW    (SPC_W),
    .STEPS (bchs_pkg::SPLIT_STEPS_B),
    .SW    (SIDE2_W)
  ) u_split_b (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_num    (s1_num),
    .in_rem    (s1_rem),
    .in_side   (s1_side),
    .divisor   (spt_div),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_num   (s2_num),
    .out_rem   (s2_rem),
    .out_side  (s2_side)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  assign s2_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s2_valid;
    end
  end

  // Sector numbers count from one
  always_ff @(posedge clk) begin
    if (s2_valid && s2_ready) begin
      cylinder     <= s2_side[CYL_W-1:0];
      sector_count <= s2_side[CYL_W +: COUNT_W];
      range_error  <= s2_side[SIDE2_W-1];
      head         <= s2_num[HEAD_W-1:0];
      sector       <= s2_rem[SPT_W-1:0] + SPT_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_sector_nonzero : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sector != '0))
    else $error("sector zero on a valid result");

  a_stall_only_when_full : assert property (@(posedge clk) disable iff (rst)
    !f_valid |-> !in_stall)
    else $error("input stalled with empty front stage");

  a_empty_after_reset : assert property (@(posedge clk)
    rst |=> (!out_valid && !f_valid))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// ----- tb/block_to_chs_address_top_tb.sv -----
// ----------------------------------------------------------------------------
// block_to_chs_address_top_tb
// Self-checking bench for the block to CHS address translator. Requests go in
// with random gaps and results come out under random output stall. Every
// accepted request is translated by a local model of the geometry math, and
// each result is compared field by field in arrival order. The geometry
// registers are reprogrammed between phases once the pipeline has drained:
// full size, one head by one sector, zero geometry, more than 16 heads, and
// random settings.
// ----------------------------------------------------------------------------
module block_to_chs_address_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADDR_W     = bchs_pkg::ADDR_W;
  localparam int COUNT_W    = bchs_pkg::COUNT_W;
  localparam int HEADS_W    = bchs_pkg::HEADS_W;
  localparam int SPT_W      = bchs_pkg::SPT_W;
  localparam int CYL_W      = bchs_pkg::CYL_W;
  localparam int HEAD_W     = bchs_pkg::HEAD_W;
  localparam int CFG_IDX_W  = bchs_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bchs_pkg::CFG_DATA_W;

  localparam int SECTORS_PER_BLOCK = bchs_pkg::SECTORS_PER_BLOCK_DEF;
  localparam int PIPE_LATENCY      = 12;
  localparam int STALL_LIMIT       = 2000;
  localparam int RANDOM_PER_PHASE  = 105;
  localparam int NUM_PHASES        = 9;
  localparam int REPORT_MAX        = 10;

  // Index past the register list; the block ignores writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic [CYL_W-1:0]   cylinder;
    logic [HEAD_W-1:0]  head;
    logic [SPT_W-1:0]   sector;
    logic [COUNT_W-1:0] sector_count;
    logic               range_error;
  } chs_addr_t;

  class chs_scoreboard;
    logic [HEADS_W-1:0] heads_reg;
    logic [SPT_W-1:0]   spt_reg;
    logic [ADDR_W-1:0]  start_reg;
    chs_addr_t          addr_q[$];
    int unsigned        mismatches;

    function new();
      heads_reg  = bchs_pkg::HEADS_RST;
      spt_reg    = bchs_pkg::SPT_RST;
      start_reg  = bchs_pkg::PSTART_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        bchs_pkg::REG_HEADS_PER_CYLINDER: heads_reg = data[HEADS_W-1:0];
        bchs_pkg::REG_SECTORS_PER_TRACK:  spt_reg   = data[SPT_W-1:0];
        bchs_pkg::REG_PARTITION_START:    start_reg = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function chs_addr_t translate(logic [ADDR_W-1:0] idx, logic [COUNT_W-1:0] cnt);
      logic [31:0] heads, spt, spc, abs_sect, cyl, rem, hd, sec, nsect;
      chs_addr_t   r;
      // zero geometry counts as one
      heads    = (heads_reg == '0) ? 32'd1 : 32'(heads_reg);
      spt      = (spt_reg == '0) ? 32'd1 : 32'(spt_reg);
      spc      = heads * spt;
      abs_sect = idx * 32'(SECTORS_PER_BLOCK) + start_reg;
      cyl      = abs_sect / spc;
      rem      = abs_sect % spc;
      hd       = rem / spt;
      sec      = 32'd1 + rem % spt;
      nsect    = 32'(cnt) * 32'(SECTORS_PER_BLOCK);
      r.cylinder     = cyl[CYL_W-1:0];
      r.head         = hd[HEAD_W-1:0];
      r.sector       = sec[SPT_W-1:0];
      r.sector_count = nsect[COUNT_W-1:0];
      r.range_error  = (cyl > 32'hFFFF) || (nsect > 32'hFF);
      return r;
    endfunction

    function void note_request(logic [ADDR_W-1:0] idx, logic [COUNT_W-1:0] cnt);
      addr_q.push_back(translate(idx, cnt));
    endfunction

    function void check_result(chs_addr_t got);
      chs_addr_t want;
      if (addr_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with nothing pending: cyl=%h head=%h sect=%h cnt=%h err=%b",
                   $realtime, got.cylinder, got.head, got.sector, got.sector_count,
                   got.range_error);
        return;
      end
      want = addr_q.pop_front();
      if (got.cylinder !== want.cylinder || got.head !== want.head ||
          got.sector !== want.sector || got.sector_count !== want.sector_count ||
          got.range_error !== want.range_error) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: mismatch exp %h %h %h %h %b, got %h %h %h %h %b",
                   $realtime, want.cylinder, want.head, want.sector, want.sector_count,
                   want.range_error, got.cylinder, got.head, got.sector,
                   got.sector_count, got.range_error);
      end
    endfunction

    function int unsigned outstanding();
      return addr_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst         = 1'b1;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [ADDR_W-1:0]     block_index = '0;
  logic [COUNT_W-1:0]    block_count = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [CYL_W-1:0]      cylinder;
  logic [HEAD_W-1:0]     head;
  logic [SPT_W-1:0]      sector;
  logic [COUNT_W-1:0]    sector_count;
  logic                  range_error;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  bit             idle_on = 1'b0;
  int unsigned    quiet_cycles = 0;
  chs_scoreboard  sb;

  block_to_chs_address_top #(
    .SECTORS_PER_BLOCK(SECTORS_PER_BLOCK)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .block_index  (block_index),
    .block_count  (block_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cylinder     (cylinder),
    .head         (head),
    .sector       (sector),
    .sector_count (sector_count),
    .range_error  (range_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one
  function automatic int unsigned pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Aim at the cylinder limit and the 32-bit wrap often, not only at random
  function automatic logic [ADDR_W-1:0] pick_index();
    logic [63:0] spc;
    logic [63:0] boundary;
    spc = 64'((sb.heads_reg == '0) ? 1 : sb.heads_reg) *
          64'((sb.spt_reg == '0) ? 1 : sb.spt_reg);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom();
      4, 5:       return $urandom_range(0, 4095);
      6: begin
        boundary = (spc << 16) - 64'(sb.start_reg);
        return 32'(boundary >> 1) + 32'($urandom_range(0, 6)) - 32'd3;
      end
      7: begin
        boundary = 64'h1_0000_0000 - 64'(sb.start_reg);
        return 32'(boundary >> 1) + 32'($urandom_range(0, 6)) - 32'd3;
      end
      8:       return {2'b11, 30'($urandom())};
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return COUNT_W'($urandom_range(0, 255));
      6:       return '0;
      7:       return '1;
      8:       return COUNT_W'($urandom_range(127, 128));
      default: return COUNT_W'($urandom_range(0, 3));
    endcase
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] idx, input logic [COUNT_W-1:0] cnt);
    in_valid    <= 1'b1;
    block_index <= idx;
    block_count <= cnt;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Junk in the upper data bits checks that the heads and sectors per track registers keep their own width
  task automatic program_geometry(input logic [HEADS_W-1:0] hpc, input logic [SPT_W-1:0] spt,
                                  input logic [ADDR_W-1:0] start);
    write_reg(bchs_pkg::REG_HEADS_PER_CYLINDER, ($urandom() & ~32'h1F) | 32'(hpc));
    write_reg(bchs_pkg::REG_SECTORS_PER_TRACK, ($urandom() & ~32'h3F) | 32'(spt));
    write_reg(bchs_pkg::REG_PARTITION_START, start);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned gap;
    for (int unsigned i = 0; i < n; i++) begin
      send_request(pick_index(), pick_count());
      gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_pause() : 0;
      if (i == n / 2) begin
        drain();
      end else if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Output stall
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_pause()) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Monitor: note accepted requests and register writes, check results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall)
        sb.note_request(block_index, block_count);
      if (out_valid && !out_stall)
        sb.check_result('{cylinder, head, sector, sector_count, range_error});
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("block_to_chs_address_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0]  dir_idx [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'd31,
      32'd32,        32'd503,       32'd504,       32'd33030143,
      32'd33030144,  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678, 32'h00FF_FF00
    };
    logic [COUNT_W-1:0] dir_cnt [16] = '{
      8'd0,   8'd255, 8'd1,  8'd127, 8'd128, 8'd129, 8'd254, 8'd1,
      8'd2,   8'd64,  8'd0,  8'd255, 8'h55,  8'hAA,  8'd3,   8'd200
    };
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: sector and cylinder edges, count overflow, address wrap
    foreach (dir_idx[i])
      send_request(dir_idx[i], dir_cnt[i]);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      repeat (PIPE_LATENCY) @(posedge clk);
      case (p)
        0: program_geometry(5'd16, 6'd63, 32'hFFFF_FFFF);
        1: program_geometry(5'd1, 6'd1, 32'h0000_0000);
        2: begin
          // zero geometry, plus a write past the register list
          program_geometry(5'd0, 6'd0, $urandom());
          write_reg(REG_SPARE, $urandom());
        end
        3: program_geometry(5'($urandom_range(17, 31)), 6'($urandom_range(1, 63)),
                            $urandom_range(0, 65535));
        4: program_geometry(5'd31, 6'd63, $urandom());
        5: program_geometry(5'd16, 6'd1, 32'hFFFF_FFFF - $urandom_range(0, 4095));
        6: begin
          write_reg(REG_SPARE, '1);
          program_geometry(5'd1, 6'd63, $urandom());
        end
        default: program_geometry(5'($urandom_range(1, 16)), 6'($urandom_range(1, 63)),
                                  $urandom());
      endcase
      idle_on = (p % 3 != 1);
      run_random(RANDOM_PER_PHASE);
      drain();
    end

    idle_on = 1'b0;
    repeat (PIPE_LATENCY + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("block_to_chs_address_top_tb OK");
    end else begin
      $display("block_to_chs_address_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/bchs_pkg.sv
hw/rtl/bchs_div_stage.sv
hw/rtl/block_to_chs_address_top.sv
tb/block_to_chs_address_top_tb.sv
